// ===== design/sns_pkg.sv =====
// ----------------------------------------------------------------------------
// sns_pkg
// Shared types, codes and constants of the spiking neuron step block.
// ----------------------------------------------------------------------------
package sns_pkg;

  localparam int RingDepth = 64;
  localparam int RingAw    = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int DelayW    = 6;
  localparam int SlotW     = ((RingAw > DelayW) ? RingAw : DelayW) + 1;

  localparam int PotW   = 32;
  localparam int DecayW = 16;
  localparam int ParW   = 31;
  localparam int TickW  = 16;
  localparam int CfgIdxW = 3;

  localparam logic [DecayW-1:0] MembraneDecayRst   = 16'd63918;
  localparam logic [DecayW-1:0] SynapticDecayRst   = 16'd62339;
  localparam logic [DecayW-1:0] RefractoryDecayRst = 16'd65209;
  localparam logic [ParW-1:0]   FireThresholdRst   = 31'd65536;
  localparam logic [ParW-1:0]   InvTauMembraneRst  = 31'd16384;
  localparam logic [ParW-1:0]   InvTauSynapticRst  = 31'd32768;
  localparam logic [ParW-1:0]   InvTauRefractRst   = 31'd3277;
  localparam logic [ParW-1:0]   SlopeFloor         = 31'd6554;

  typedef logic [RingAw-1:0] slot_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SPIKE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MEMBRANE_DECAY   = 3'd0,
    CFG_SYNAPTIC_DECAY   = 3'd1,
    CFG_REFRACTORY_DECAY = 3'd2,
    CFG_FIRE_THRESHOLD   = 3'd3,
    CFG_INV_TAU_MEMBRANE = 3'd4,
    CFG_INV_TAU_SYNAPTIC = 3'd5,
    CFG_INV_TAU_REFRACT  = 3'd6,
    CFG_SINGLE_SPIKE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPK_WR,
    ST_DEC_M,
    ST_DEC_S,
    ST_DEC_R,
    ST_SUM,
    ST_SLP_R,
    ST_SLP_M,
    ST_SLP_S,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   rd_en;
    logic                   kill_en;
    logic                   wr_en;
    logic                   flush;
    slot_t                  rd_addr;
    slot_t                  wr_addr;
    logic signed [PotW-1:0] wr_data;
  } ring_req_t;

endpackage

// ===== design/sns_if.sv =====
// ----------------------------------------------------------------------------
// sns_if
// Valid/ready channels of the spiking neuron step block.
// ----------------------------------------------------------------------------
interface sns_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic signed [sns_pkg::PotW-1:0]     spike_weight;
  logic [sns_pkg::DelayW-1:0]          delay_ticks;

  modport source (output valid, command, spike_weight, delay_ticks, input ready);
  modport sink   (input valid, command, spike_weight, delay_ticks, output ready);
endinterface

interface sns_out_if;
  logic                                valid;
  logic                                ready;
  logic                                fired;
  logic [sns_pkg::TickW-1:0]           spike_tick;
  logic [sns_pkg::ParW-1:0]            slope;
  logic signed [sns_pkg::PotW-1:0]     potential;

  modport source (output valid, fired, spike_tick, slope, potential, input ready);
  modport sink   (input valid, fired, spike_tick, slope, potential, output ready);
endinterface

// ===== design/sns_ring.sv =====
// ----------------------------------------------------------------------------
// sns_ring
// Arrival ring: one-port-read, one-port-write slot memory with per-slot
// valid bits; an invalid slot reads as zero.
// ----------------------------------------------------------------------------
module sns_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sns_pkg::ring_req_t              req_i,
  output logic signed [sns_pkg::PotW-1:0] rd_data_o
);

  logic signed [sns_pkg::PotW-1:0] mem [sns_pkg::RingDepth];
  logic [sns_pkg::RingDepth-1:0]   vld_q;
  logic signed [sns_pkg::PotW-1:0] rd_data_q;
  logic                            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
      if (req_i.flush) begin
        vld_q <= '0;
      end else begin
        if (req_i.kill_en) begin
          vld_q[req_i.rd_addr] <= 1'b0;
        end
        if (req_i.wr_en) begin
          vld_q[req_i.wr_addr] <= 1'b1;
        end
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/spiking_neuron_step.sv =====
// ----------------------------------------------------------------------------
// spiking_neuron_step
// Spike response model neuron: three decaying potentials, an arrival ring
// of delayed weights and threshold firing with slope output.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A spike beat reads the ring, then does the
// saturating add and write back; a clear acts in the idle state. A tick runs
// the three decays, the sum and the output state, adds the three slope states
// when the neuron fires and skips the decays when frozen in single-spike mode.
// One shared 32x32 multiplier does the three decays and three slope products
// one per cycle. Ticks produce one result beat each; spikes and clears none.
// The ring is emptied at reset and on clear by per-slot valid bits, no sweep.
module spiking_neuron_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sns_in_if.sink                        in_i,
  sns_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [sns_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sns_pkg::ParW-1:0]      cfg_data_i
);

  localparam int PW  = sns_pkg::PotW;
  localparam int AccW = 50;

  function automatic logic signed [PW-1:0] sat32(input logic signed [PW+1:0] v);
    if (v > $signed({3'b000, {(PW-1){1'b1}}})) begin
      return {1'b0, {(PW-1){1'b1}}};
    end else if (v < $signed({3'b111, {(PW-1){1'b0}}})) begin
      return {1'b1, {(PW-1){1'b0}}};
    end
    return v[PW-1:0];
  endfunction

  // configuration
  logic [sns_pkg::DecayW-1:0] m_decay_q, s_decay_q, r_decay_q;
  logic [sns_pkg::ParW-1:0]   thr_q, itm_q, its_q, itr_q;
  logic                       single_q;

  // neuron state
  sns_pkg::state_e            state_q, state_d;
  logic signed [PW-1:0]       mp_q, sp_q, rp_q;
  logic [sns_pkg::TickW-1:0]  tick_q;
  sns_pkg::slot_t             head_q;
  logic                       has_fired_q;

  // datapath
  logic signed [2*PW-1:0]     prod_q;
  logic signed [PW-1:0]       mul_a;
  logic signed [PW-1:0]       mul_b;
  logic signed [PW-1:0]       due_q;
  logic signed [PW-1:0]       w_q;
  sns_pkg::slot_t             slot_q;
  logic signed [PW+1:0]       sum_q;
  logic signed [PW+1:0]       sum;
  logic                       fire_q;
  logic                       frozen;
  logic signed [AccW-1:0]     acc_q;
  logic signed [AccW-1:0]     neg_acc;
  logic [sns_pkg::ParW-1:0]   slope;
  logic signed [PW-1:0]       due;
  logic signed [PW-1:0]       dec;
  logic signed [AccW-1:0]     term;

  // output register
  logic                       out_vld_q;
  logic                       out_fired_q;
  logic [sns_pkg::TickW-1:0]  out_tick_q;
  logic [sns_pkg::ParW-1:0]   out_slope_q;
  logic signed [PW-1:0]       out_pot_q;
  logic                       out_load;

  // handshake and ring
  logic                       in_beat;
  sns_pkg::cmd_e              cmd;
  sns_pkg::ring_req_t         ring_req;
  logic [sns_pkg::SlotW-1:0]  dly_w;
  logic [sns_pkg::SlotW-1:0]  slot_sum;
  sns_pkg::slot_t             spk_slot;

  sns_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (due)
  );

  assign in_i.ready = (state_q == sns_pkg::ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign cmd        = sns_pkg::cmd_e'(in_i.command);
  assign frozen     = single_q && has_fired_q;

  // slot for a spike: head + clamped delay, modulo ring depth
  always_comb begin
    dly_w = sns_pkg::SlotW'(in_i.delay_ticks);
    if (dly_w >= sns_pkg::SlotW'(sns_pkg::RingDepth)) begin
      dly_w = sns_pkg::SlotW'(sns_pkg::RingDepth - 1);
    end
    slot_sum = sns_pkg::SlotW'(head_q) + dly_w;
    if (slot_sum >= sns_pkg::SlotW'(sns_pkg::RingDepth)) begin
      slot_sum = slot_sum - sns_pkg::SlotW'(sns_pkg::RingDepth);
    end
    spk_slot = slot_sum[sns_pkg::RingAw-1:0];
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      sns_pkg::ST_IDLE:  begin mul_a = mp_q; mul_b = PW'(m_decay_q); end
      sns_pkg::ST_DEC_M: begin mul_a = sp_q; mul_b = PW'(s_decay_q); end
      sns_pkg::ST_DEC_S: begin mul_a = rp_q; mul_b = PW'(r_decay_q); end
      sns_pkg::ST_SUM:   begin mul_a = rp_q; mul_b = PW'(itr_q); end
      sns_pkg::ST_SLP_R: begin mul_a = mp_q; mul_b = PW'(itm_q); end
      sns_pkg::ST_SLP_M: begin mul_a = sp_q; mul_b = PW'(its_q); end
      default:           begin mul_a = mp_q; mul_b = PW'(m_decay_q); end
    endcase
  end

  assign dec  = prod_q[PW+15:16];
  assign term = AccW'($signed(prod_q[2*PW-1:16]));
  assign sum  = (PW+2)'(mp_q) + (PW+2)'(sp_q) + (PW+2)'(rp_q);

  always_comb begin
    neg_acc = -acc_q;
    if (neg_acc < $signed(AccW'(sns_pkg::SlopeFloor))) begin
      slope = sns_pkg::SlopeFloor;
    end else if (neg_acc > $signed(AccW'({sns_pkg::ParW{1'b1}}))) begin
      slope = {sns_pkg::ParW{1'b1}};
    end else begin
      slope = neg_acc[sns_pkg::ParW-1:0];
    end
  end

  // control: next state, ring requests
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    ring_req = '0;
    ring_req.wr_addr = slot_q;
    ring_req.wr_data = sat32((PW+2)'(due) + (PW+2)'(w_q));
    unique case (state_q)
      sns_pkg::ST_IDLE: begin
        if (in_beat) begin
          unique case (cmd)
            sns_pkg::CMD_TICK: begin
              ring_req.rd_en   = 1'b1;
              ring_req.kill_en = 1'b1;
              ring_req.rd_addr = head_q;
              state_d = frozen ? sns_pkg::ST_SUM : sns_pkg::ST_DEC_M;
            end
            sns_pkg::CMD_SPIKE: begin
              ring_req.rd_en   = 1'b1;
              ring_req.rd_addr = spk_slot;
              state_d = sns_pkg::ST_SPK_WR;
            end
            sns_pkg::CMD_CLEAR: begin
              ring_req.flush = 1'b1;
            end
            default: ;
          endcase
        end
      end
      sns_pkg::ST_SPK_WR: begin
        ring_req.wr_en = 1'b1;
        state_d = sns_pkg::ST_IDLE;
      end
      sns_pkg::ST_DEC_M: state_d = sns_pkg::ST_DEC_S;
      sns_pkg::ST_DEC_S: state_d = sns_pkg::ST_DEC_R;
      sns_pkg::ST_DEC_R: state_d = sns_pkg::ST_SUM;
      sns_pkg::ST_SUM: begin
        if (!frozen && sum >= $signed((PW+2)'(thr_q))) begin
          state_d = sns_pkg::ST_SLP_R;
        end else begin
          state_d = sns_pkg::ST_OUT;
        end
      end
      sns_pkg::ST_SLP_R: state_d = sns_pkg::ST_SLP_M;
      sns_pkg::ST_SLP_M: state_d = sns_pkg::ST_SLP_S;
      sns_pkg::ST_SLP_S: state_d = sns_pkg::ST_OUT;
      sns_pkg::ST_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = sns_pkg::ST_IDLE;
        end
      end
      default: state_d = sns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sns_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_decay_q <= sns_pkg::MembraneDecayRst;
      s_decay_q <= sns_pkg::SynapticDecayRst;
      r_decay_q <= sns_pkg::RefractoryDecayRst;
      thr_q     <= sns_pkg::FireThresholdRst;
      itm_q     <= sns_pkg::InvTauMembraneRst;
      its_q     <= sns_pkg::InvTauSynapticRst;
      itr_q     <= sns_pkg::InvTauRefractRst;
      single_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (sns_pkg::cfg_idx_e'(cfg_idx_i))
        sns_pkg::CFG_MEMBRANE_DECAY:   m_decay_q <= cfg_data_i[sns_pkg::DecayW-1:0];
        sns_pkg::CFG_SYNAPTIC_DECAY:   s_decay_q <= cfg_data_i[sns_pkg::DecayW-1:0];
        sns_pkg::CFG_REFRACTORY_DECAY: r_decay_q <= cfg_data_i[sns_pkg::DecayW-1:0];
        sns_pkg::CFG_FIRE_THRESHOLD:   thr_q     <= cfg_data_i;
        sns_pkg::CFG_INV_TAU_MEMBRANE: itm_q     <= cfg_data_i;
        sns_pkg::CFG_INV_TAU_SYNAPTIC: its_q     <= cfg_data_i;
        sns_pkg::CFG_INV_TAU_REFRACT:  itr_q     <= cfg_data_i;
        sns_pkg::CFG_SINGLE_SPIKE:     single_q  <= cfg_data_i[0];
      endcase
    end
  end

  // neuron state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q        <= '0;
      sp_q        <= '0;
      rp_q        <= '0;
      tick_q      <= '0;
      head_q      <= '0;
      has_fired_q <= 1'b0;
    end else begin
      unique case (state_q)
        sns_pkg::ST_IDLE: begin
          if (in_beat && cmd == sns_pkg::CMD_CLEAR) begin
            mp_q        <= '0;
            sp_q        <= '0;
            rp_q        <= '0;
            tick_q      <= '0;
            head_q      <= '0;
            has_fired_q <= 1'b0;
          end
        end
        sns_pkg::ST_DEC_M: mp_q <= sat32((PW+2)'(dec) + (PW+2)'(due));
        sns_pkg::ST_DEC_S: sp_q <= sat32((PW+2)'(dec) - (PW+2)'(due_q));
        sns_pkg::ST_DEC_R: rp_q <= dec;
        sns_pkg::ST_OUT: begin
          if (out_load) begin
            tick_q <= tick_q + 1'b1;
            head_q <= (head_q == sns_pkg::slot_t'(sns_pkg::RingDepth - 1)) ?
                      '0 : head_q + 1'b1;
            if (fire_q) begin
              has_fired_q <= 1'b1;
              rp_q <= sat32((PW+2)'(rp_q) - (PW+2)'(thr_q));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_beat) begin
      w_q    <= in_i.spike_weight;
      slot_q <= spk_slot;
    end
    if (state_q == sns_pkg::ST_DEC_M) begin
      due_q <= due;
    end
    if (state_q == sns_pkg::ST_SUM) begin
      sum_q  <= sum;
      fire_q <= !frozen && sum >= $signed((PW+2)'(thr_q));
    end
    unique case (state_q)
      sns_pkg::ST_SLP_R: acc_q <= term;
      sns_pkg::ST_SLP_M,
      sns_pkg::ST_SLP_S: acc_q <= acc_q + term;
      default: ;
    endcase
    if (out_load) begin
      out_fired_q <= fire_q;
      out_tick_q  <= tick_q;
      out_slope_q <= fire_q ? slope : '0;
      out_pot_q   <= sat32(sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.fired      = out_fired_q;
  assign out_o.spike_tick = out_tick_q;
  assign out_o.slope      = out_slope_q;
  assign out_o.potential  = out_pot_q;

`ifndef NO_ASSERTIONS
  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == sns_pkg::ST_OUT))
    else $error("result beat without a finished tick");

  a_slope_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.fired) |-> (out_o.slope >= sns_pkg::SlopeFloor))
    else $error("fired result below slope floor");

  a_frozen_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sns_pkg::ST_SUM && frozen) |=> !fire_q)
    else $error("frozen neuron fired");

  a_spike_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sns_pkg::ST_SPK_WR) |-> $past(state_q == sns_pkg::ST_IDLE && in_beat))
    else $error("ring write back without a spike read");
`endif

endmodule
